>>> hw/rtl/dfs_pkg.sv
`timescale 1ns / 1ps

package dfs_pkg;

  // Fixed field widths
  localparam int NodeW = 4;
  localparam int CfgW  = 5;

  // Default sizes
  localparam int DefMaxNodes = 16;
  localparam int DefMaxEdges = 64;

  localparam logic [CfgW-1:0] NodeCountRst = CfgW'(8);

  typedef enum logic [1:0] {
    ActAddEdge = 2'd0,
    ActRun     = 2'd1,
    ActClear   = 2'd2
  } dfs_action_e;

  typedef enum logic [2:0] {
    StIdle,
    StRoot,
    StScan,
    StPop,
    StEmit
  } dfs_state_e;

endpackage

>>> hw/rtl/dfs_topological_sort_core.sv
`timescale 1ns / 1ps

// Depth-first topological sort engine. Edges are loaded one item per cycle
// (action add edge) into an edge memory in load order; a clear item empties
// it, and edges beyond MAX_EDGES are dropped and reported on edges_dropped_o
// until the next clear. Add edge and clear items finish in the cycle they are
// accepted and busy_o never rises for them. A run item clears the visited
// marks and walks the graph depth first, roots in ascending order and
// successors in load order, using a stack memory of (node, edge cursor)
// frames; edges touching a node at or above node_count (capped at MAX_NODES)
// are skipped. Once the walk is done, the nodes stream out in reverse
// finishing order, one per cycle on result_valid_o, last_o marking the final
// one. busy_o is high for the whole run and start_i is ignored meanwhile.
// During a run the single read port of the edge memory examines one edge per
// cycle; a return to a parent frame goes through a stack read (StPop) before
// the scan of that frame resumes.
// The receiver cannot stall results; they are valid for exactly one cycle.
// node_count may be written only while busy_o is low.
module dfs_topological_sort_core
  import dfs_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes,
  parameter int MAX_EDGES = DefMaxEdges
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_node_count_i,
  // item in
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       action_i,
  input  logic [NodeW-1:0] src_node_i,
  input  logic [NodeW-1:0] dst_node_i,
  // results out
  output logic             result_valid_o,
  output logic [NodeW-1:0] order_node_o,
  output logic             last_o,
  output logic             edges_dropped_o
);

  localparam int NIW  = $clog2(MAX_NODES);      // node index
  localparam int NCW  = $clog2(MAX_NODES + 1);  // node count
  localparam int AW   = $clog2(MAX_EDGES);      // edge address
  localparam int EW   = $clog2(MAX_EDGES + 1);  // edge count / cursor
  localparam int CMPW = (NCW > CfgW) ? NCW : CfgW;
  localparam int SW   = NIW + EW;               // stack frame

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  dfs_state_e           state_q, state_d;
  logic [CfgW-1:0]      node_count_q;
  logic [EW-1:0]        edge_total_q, edge_total_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic [NCW-1:0]       n_q, n_d;
  logic [NCW-1:0]       root_q, root_d;
  logic [NCW-1:0]       depth_q, depth_d;
  logic [NCW-1:0]       done_q, done_d;
  logic [NCW-1:0]       ep_q, ep_d;
  logic [NIW-1:0]       top_node_q, top_node_d;
  logic [EW-1:0]        top_cur_q, top_cur_d;

  // ---------------------------------------------------------------------------
  // Memories: edge list, walk stack, finish order
  // ---------------------------------------------------------------------------
  logic [NodeW-1:0] edge_src_mem [MAX_EDGES];
  logic [NodeW-1:0] edge_dst_mem [MAX_EDGES];
  logic [SW-1:0]    stack_mem    [MAX_NODES];
  logic [NodeW-1:0] order_mem    [MAX_NODES];

  logic [NodeW-1:0] edge_src_rd_q, edge_dst_rd_q;
  logic [SW-1:0]    stack_rd_q;
  logic [NodeW-1:0] order_rd_q;

  logic             edge_we;
  logic [AW-1:0]    edge_raddr;
  logic             stack_we;
  logic [NIW-1:0]   stack_waddr, stack_raddr;
  logic [SW-1:0]    stack_wdata;
  logic             order_we;
  logic [NIW-1:0]   order_waddr, order_raddr;
  logic [NodeW-1:0] order_wdata;

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_src_mem[edge_total_q[AW-1:0]] <= src_node_i;
      edge_dst_mem[edge_total_q[AW-1:0]] <= dst_node_i;
    end
    edge_src_rd_q <= edge_src_mem[edge_raddr];
    edge_dst_rd_q <= edge_dst_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    order_rd_q <= order_mem[order_raddr];
  end

  // ---------------------------------------------------------------------------
  // Compare helpers (common width)
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0] cnt_ext, max_ext, n_ext, src_ext, dst_ext, top_ext;
  logic [NCW-1:0]  n_run;
  logic            accept;
  logic            edge_hit;
  logic            depth_room;
  logic [NCW-1:0]  depth_m1, depth_m2;
  logic [EW-1:0]   cur_inc;
  logic [NIW-1:0]  dst_idx;

  assign cnt_ext = CMPW'(node_count_q);
  assign max_ext = CMPW'(MAX_NODES);
  assign n_run   = (cnt_ext > max_ext) ? max_ext[NCW-1:0] : cnt_ext[NCW-1:0];
  assign n_ext   = CMPW'(n_q);
  assign src_ext = CMPW'(edge_src_rd_q);
  assign dst_ext = CMPW'(edge_dst_rd_q);
  assign top_ext = CMPW'(top_node_q);
  assign dst_idx = dst_ext[NIW-1:0];

  assign accept     = start_i && (state_q == StIdle);
  // read data matches top_cur_q: the read address always follows top_cur_d
  assign edge_hit   = (src_ext == top_ext) && (dst_ext < n_ext) && !visited_q[dst_idx];
  assign depth_room = depth_q < NCW'(MAX_NODES);
  assign depth_m1   = depth_q - NCW'(1);
  assign depth_m2   = depth_q - NCW'(2);
  assign cur_inc    = top_cur_q + EW'(1);

  assign edge_raddr  = top_cur_d[AW-1:0];
  assign order_raddr = ep_d[NIW-1:0];

  // ---------------------------------------------------------------------------
  // Next state and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    ovf_d        = ovf_q;
    visited_d    = visited_q;
    n_d          = n_q;
    root_d       = root_q;
    depth_d      = depth_q;
    done_d       = done_q;
    ep_d         = ep_q;
    top_node_d   = top_node_q;
    top_cur_d    = top_cur_q;
    edge_we      = 1'b0;
    stack_we     = 1'b0;
    stack_waddr  = depth_m1[NIW-1:0];
    stack_wdata  = {top_node_q, cur_inc};
    stack_raddr  = depth_m2[NIW-1:0];
    order_we     = 1'b0;
    order_waddr  = done_q[NIW-1:0];
    order_wdata  = top_ext[NodeW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (action_i)
            ActAddEdge: begin
              if (edge_total_q < EW'(MAX_EDGES)) begin
                edge_we      = 1'b1;
                edge_total_d = edge_total_q + EW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            ActRun: begin
              visited_d = '0;
              n_d       = n_run;
              root_d    = '0;
              done_d    = '0;
              state_d   = StRoot;
            end
            ActClear: begin
              edge_total_d = '0;
              ovf_d        = 1'b0;
            end
            default: ;
          endcase
        end
      end

      StRoot: begin
        if (root_q >= n_q) begin
          if (done_q == '0) begin
            state_d = StIdle;
          end else begin
            ep_d    = done_q - NCW'(1);
            state_d = StEmit;
          end
        end else begin
          root_d = root_q + NCW'(1);
          if (!visited_q[root_q[NIW-1:0]]) begin
            visited_d[root_q[NIW-1:0]] = 1'b1;
            top_node_d = root_q[NIW-1:0];
            top_cur_d  = '0;
            depth_d    = NCW'(1);
            state_d    = StScan;
          end
        end
      end

      StScan: begin
        if (top_cur_q >= edge_total_q) begin
          // node finished
          if (done_q < NCW'(MAX_NODES)) begin
            order_we = 1'b1;
            done_d   = done_q + NCW'(1);
          end
          depth_d = depth_m1;
          if (depth_q == NCW'(1)) begin
            state_d = StRoot;
          end else begin
            state_d = StPop;
          end
        end else if (edge_hit) begin
          visited_d[dst_idx] = 1'b1;
          if (depth_room) begin
            stack_we   = 1'b1;
            top_node_d = dst_idx;
            top_cur_d  = '0;
            depth_d    = depth_q + NCW'(1);
          end else begin
            top_cur_d = cur_inc;
          end
        end else begin
          top_cur_d = cur_inc;
        end
      end

      StPop: begin
        top_node_d = stack_rd_q[SW-1:EW];
        top_cur_d  = stack_rd_q[EW-1:0];
        state_d    = StScan;
      end

      StEmit: begin
        if (ep_q == '0) begin
          state_d = StIdle;
        end else begin
          ep_d = ep_q - NCW'(1);
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    busy_o          = (state_q != StIdle);
    result_valid_o  = (state_q == StEmit);
    last_o          = (state_q == StEmit) && (ep_q == '0);
    order_node_o    = order_rd_q;
    edges_dropped_o = ovf_q;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      node_count_q <= NodeCountRst;
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
      visited_q    <= '0;
      n_q          <= '0;
      root_q       <= '0;
      depth_q      <= '0;
      done_q       <= '0;
      ep_q         <= '0;
      top_node_q   <= '0;
      top_cur_q    <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_node_count_i;
      end
      edge_total_q <= edge_total_d;
      ovf_q        <= ovf_d;
      visited_q    <= visited_d;
      n_q          <= n_d;
      root_q       <= root_d;
      depth_q      <= depth_d;
      done_q       <= done_d;
      ep_q         <= ep_d;
      top_node_q   <= top_node_d;
      top_cur_q    <= top_cur_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !busy_o)
    else $error("run did not end after last result");

  a_scan_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (depth_q != '0))
    else $error("edge scan with empty walk stack");

  a_done_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (done_q <= n_q))
    else $error("more finished nodes than active nodes");

  a_cursor_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (top_cur_q <= edge_total_q))
    else $error("edge cursor past end of edge list");

endmodule

>>> test/dfs_topological_sort_core_tb.sv
`timescale 1ns / 1ps

module dfs_topological_sort_core_tb;
  import dfs_pkg::*;

  localparam int MaxNodes   = DefMaxNodes;
  localparam int MaxEdges   = DefMaxEdges;
  localparam int StallLimit = 20000;  // watchdog bound on cycles with no item taken and no node emitted
  localparam int RandItems  = 224;

  // Action code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] ActReserved = 2'd3;

  // One emitted node as seen on the result ports.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             last;
    logic             dropped;
  } order_item_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             cfg_we_i         = 1'b0;
  logic [CfgW-1:0]  cfg_node_count_i = '0;
  logic             start_i          = 1'b0;
  logic             busy_o;
  logic [1:0]       action_i         = '0;
  logic [NodeW-1:0] src_node_i       = '0;
  logic [NodeW-1:0] dst_node_i       = '0;
  logic             result_valid_o;
  logic [NodeW-1:0] order_node_o;
  logic             last_o;
  logic             edges_dropped_o;

  dfs_topological_sort_core #(
    .MAX_NODES (MaxNodes),
    .MAX_EDGES (MaxEdges)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_node_count_i (cfg_node_count_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .src_node_i       (src_node_i),
    .dst_node_i       (dst_node_i),
    .result_valid_o   (result_valid_o),
    .order_node_o     (order_node_o),
    .last_o           (last_o),
    .edges_dropped_o  (edges_dropped_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: edge list, drop flag and node count register.
  // ---------------------------------------------------------------------------
  logic [NodeW-1:0] shadow_src [MaxEdges];
  logic [NodeW-1:0] shadow_dst [MaxEdges];
  int               shadow_edge_cnt = 0;
  logic             shadow_dropped  = 1'b0;
  logic [CfgW-1:0]  shadow_node_cnt = NodeCountRst;

  order_item_t      topo_order_q [$];   // emitted nodes still to arrive
  int               err_cnt   = 0;
  int               items_sent = 0;     // items that do something (not reserved)
  int               idle_pct  = 0;      // sender idle chance per item, percent

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t mismatch: %s expected %0d got %0d", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Depth-first walk over the shadow edge list; appends the reverse finishing
  // order to topo_order_q.
  task automatic predict_order();
    int               n;
    int               done;
    int               depth;
    int               top;
    int               e;
    bit               pushed;
    logic [NodeW-1:0] v;
    logic [NodeW-1:0] s;
    logic [NodeW-1:0] d;
    logic [MaxNodes-1:0] seen;
    logic [NodeW-1:0] frame_node [MaxNodes];
    int               frame_cur  [MaxNodes];
    logic [NodeW-1:0] finished   [MaxNodes];
    order_item_t      it;
    n    = (shadow_node_cnt > MaxNodes) ? MaxNodes : int'(shadow_node_cnt);
    seen = '0;
    done = 0;
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      seen[root]    = 1'b1;
      frame_node[0] = NodeW'(root);
      frame_cur[0]  = 0;
      depth         = 1;
      while (depth > 0) begin
        top    = depth - 1;
        v      = frame_node[top];
        e      = frame_cur[top];
        pushed = 1'b0;
        while (e < shadow_edge_cnt && e < MaxEdges) begin
          s = shadow_src[e];
          d = shadow_dst[e];
          e++;
          // out-of-range targets and already seen nodes are not followed
          if (s == v && d < n && !seen[d]) begin
            frame_cur[top] = e;
            seen[d]        = 1'b1;
            if (depth < MaxNodes) begin
              frame_node[depth] = d;
              frame_cur[depth]  = 0;
              depth++;
            end
            pushed = 1'b1;
            break;
          end
        end
        if (!pushed) begin
          frame_cur[top] = e;
          if (done < MaxNodes) begin
            finished[done] = v;
            done++;
          end
          depth--;
        end
      end
    end
    for (int k = 0; k < done; k++) begin
      it.node    = finished[done - 1 - k];
      it.last    = (k + 1 == done);
      it.dropped = shadow_dropped;
      topo_order_q.insert(topo_order_q.size(), it);
    end
  endtask

  task automatic apply_item(input logic [1:0] act, input logic [NodeW-1:0] src,
                            input logic [NodeW-1:0] dst);
    case (act)
      ActAddEdge: begin
        if (shadow_edge_cnt < MaxEdges) begin
          shadow_src[shadow_edge_cnt] = src;
          shadow_dst[shadow_edge_cnt] = dst;
          shadow_edge_cnt++;
        end else begin
          shadow_dropped = 1'b1;
        end
      end
      ActRun:   predict_order();
      ActClear: begin
        shadow_edge_cnt = 0;
        shadow_dropped  = 1'b0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge that took the item,
  // or after a random idle gap. start_i stays high between back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] act, input logic [NodeW-1:0] src,
                           input logic [NodeW-1:0] dst);
    int gap;
    start_i    <= 1'b1;
    action_i   <= act;
    src_node_i <= src;
    dst_node_i <= dst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_item(act, src, dst);
    if (act != ActReserved) items_sent++;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until the block has emitted everything and dropped busy.
  task automatic wait_block_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (topo_order_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [CfgW-1:0] value);
    wait_block_idle();
    cfg_we_i         <= 1'b1;
    cfg_node_count_i <= value;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    shadow_node_cnt  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed node is matched against the oldest entry.
  // ---------------------------------------------------------------------------
  order_item_t got_item;
  order_item_t want_item;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      got_item = '{node: order_node_o, last: last_o, dropped: edges_dropped_o};
      if (topo_order_q.size() == 0) begin
        report_mismatch("result with nothing pending, node", -1, got_item.node);
      end else begin
        want_item = topo_order_q.pop_front();
        if (got_item.node !== want_item.node)
          report_mismatch("order_node", want_item.node, got_item.node);
        if (got_item.last !== want_item.last)
          report_mismatch("last", want_item.last, got_item.last);
        if (got_item.dropped !== want_item.dropped)
          report_mismatch("edges_dropped", want_item.dropped, got_item.dropped);
      end
    end
  end

  // Watchdog: cycles with no item taken and no node emitted.
  int stall_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default node count, empty list, a small diamond with a back edge, a self
  // loop, out-of-range nodes, an ignored action, and the node count extremes.
  task automatic test_directed_graphs();
    send_item(ActRun, '0, '0);                  // no edges: 7 down to 0
    send_item(ActAddEdge, 4'd3, 4'd1);
    send_item(ActAddEdge, 4'd1, 4'd0);
    send_item(ActAddEdge, 4'd3, 4'd2);
    send_item(ActAddEdge, 4'd2, 4'd0);
    send_item(ActAddEdge, 4'd0, 4'd3);          // closes a cycle
    send_item(ActAddEdge, 4'd1, 4'd1);          // self loop
    send_item(ActAddEdge, 4'd9, 4'd2);          // source out of range at 8
    send_item(ActAddEdge, 4'd2, 4'd15);         // target out of range at 8
    send_item(ActAddEdge, 4'd15, 4'd15);
    send_item(ActAddEdge, 4'd6, 4'd7);
    send_item(ActReserved, 4'd15, 4'd15);       // must be ignored
    send_item(ActRun, '0, '0);
    write_node_count(CfgW'(16));                // now 9, 15 take part
    send_item(ActRun, '0, '0);
    write_node_count(CfgW'(1));
    send_item(ActRun, '0, '0);
    write_node_count(CfgW'(0));                 // run emits nothing
    send_item(ActRun, '0, '0);
    write_node_count(CfgW'(31));                // clipped to the node limit
    send_item(ActRun, '0, '0);
    send_item(ActClear, 4'd15, 4'd15);
    send_item(ActRun, '0, '0);
  endtask

  // Fill the edge list past capacity, run with the drop flag up, then clear and run again.
  task automatic test_edge_overflow();
    write_node_count(CfgW'(16));
    send_item(ActClear, '0, '0);
    for (int i = 0; i < MaxEdges + 3; i++)
      send_item(ActAddEdge, NodeW'(i % 15), NodeW'((i % 15) + 1));
    send_item(ActRun, '0, '0);
    send_item(ActClear, '0, '0);
    send_item(ActRun, '0, '0);
  endtask

  // One random sequence: mostly clear, a handful of edges, run. Some skip the
  // clear so the list piles up; a few are pure noise.
  task automatic random_sequence();
    int               roll;
    int               n_edges;
    int               hi;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic [CfgW-1:0]  cnt;
    if ($urandom_range(99) < 20) begin
      roll = $urandom_range(99);
      if (roll < 70)      cnt = CfgW'($urandom_range(1, 16));
      else if (roll < 80) cnt = CfgW'(0);
      else                cnt = CfgW'($urandom_range(17, 31));
      write_node_count(cnt);
    end else if ($urandom_range(99) < 10) begin
      wait_block_idle();                         // let the queue run dry
    end
    hi   = ((shadow_node_cnt > MaxNodes) ? MaxNodes : int'(shadow_node_cnt)) - 1;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6))
        send_item(2'($urandom_range(3)), NodeW'($urandom), NodeW'($urandom));
    end else begin
      if (roll >= 15) send_item(ActClear, NodeW'($urandom), NodeW'($urandom));
      n_edges = (roll >= 95) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      repeat (n_edges) begin
        if ($urandom_range(9) < 6 && hi >= 1) begin
          // forward edge inside the active range keeps the graph acyclic
          src = NodeW'($urandom_range(0, hi - 1));
          dst = NodeW'($urandom_range(int'(src) + 1, hi));
        end else begin
          src = NodeW'($urandom);
          dst = NodeW'($urandom);
        end
        send_item(ActAddEdge, src, dst);
      end
      send_item(ActRun, NodeW'($urandom), NodeW'($urandom));
    end
  endtask

  task automatic test_random_phase(input int pct, input int n_items);
    int target;
    idle_pct = pct;
    target   = items_sent + n_items;
    while (items_sent < target) random_sequence();
    wait_block_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_graphs();
    test_edge_overflow();
    items_sent = 0;
    test_random_phase(0, RandItems / 4);
    test_random_phase(67, RandItems / 4);
    test_random_phase(0, RandItems / 4);
    test_random_phase(6, RandItems / 4);

    wait_block_idle();
    repeat (30) @(posedge clk_i);
    if (topo_order_q.size() != 0)
      report_mismatch("nodes never emitted, count", 0, topo_order_q.size());
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_topological_sort_core.sv
test/dfs_topological_sort_core_tb.sv
